@@ rtl/core/mesh_box_element_index_generator_top_macros.svh @@
// Assertion macros shared by the box walk address generator
`ifndef MESH_BOX_ELEMENT_INDEX_GENERATOR_TOP_MACROS_SVH
`define MESH_BOX_ELEMENT_INDEX_GENERATOR_TOP_MACROS_SVH

// Clocked property, disabled while reset is high
`define MBEIG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MBEIG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   `MBEIG_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

@@ rtl/core/mbeig_pkg.sv @@
// Shared types and constants of the box walk address generator
package mbeig_pkg;

   localparam int COORD_W        = 11;
   localparam int VAL_W          = 12;
   localparam int SUB_W          = 3;
   localparam int ELEM_W         = 33;
   localparam int DIMS_W         = 2;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 11;
   localparam int DEF_MAX_EXTENT = 1024;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [DIMS_W-1:0] DIMS_1D = 2'd1;
   localparam logic [DIMS_W-1:0] DIMS_2D = 2'd2;
   localparam logic [DIMS_W-1:0] DIMS_3D = 2'd3;

   localparam logic [SUB_W-1:0] PER_1D = 3'd1;
   localparam logic [SUB_W-1:0] PER_2D = 3'd2;
   localparam logic [SUB_W-1:0] PER_3D = 3'd6;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DIMS     = 2'd0,
      REG_EXTENT_X = 2'd1,
      REG_EXTENT_Y = 2'd2,
      REG_EXTENT_Z = 2'd3
   } reg_index_type;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic      action;
      coord_type low_x;
      coord_type low_y;
      coord_type low_z;
      coord_type high_x;
      coord_type high_y;
      coord_type high_z;
   } req_type;

   typedef struct packed {
      coord_type          sec_x;
      coord_type          sec_y;
      coord_type          sec_z;
      logic [SUB_W-1:0]   sub_index;
      logic [ELEM_W-1:0]  element_number;
      logic               finished;
      logic               misuse;
   } rsp_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_type;

   typedef struct packed {
      op_type    op;
      coord_type low_x;
      coord_type low_y;
      coord_type low_z;
      coord_type high_x;
      coord_type high_y;
      coord_type high_z;
   } cmd_type;

   typedef struct packed {
      logic [DIMS_W-1:0] dims;
      coord_type         extent_x;
      coord_type         extent_y;
      coord_type         extent_z;
   } cfg_type;

endpackage

@@ rtl/core/mbeig_chan_if.sv @@
// Valid/ready channel carrying one payload per transaction
interface mbeig_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/mbeig_queue.sv @@
// Small command queue between the front and back parts
module mbeig_queue #(
   parameter int DEPTH = mbeig_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mbeig_pkg::cmd_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output mbeig_pkg::cmd_type head
);
   import mbeig_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cmd_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

@@ rtl/core/mbeig_front.sv @@
// Front part: takes request transactions, decodes them and queues commands
module mbeig_front #(
   parameter int DEPTH = mbeig_pkg::QUEUE_DEPTH
) (
   input logic          clock,
   input logic          reset,
   mbeig_chan_if.sink   req_ch,
   mbeig_chan_if.source cmd_ch
);
   import mbeig_pkg::*;

   cmd_type cmd;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;

   // Corners matter only on start; drop them for an advance
   always_comb begin
      cmd = '0;
      if (req_ch.payload.action) begin
         cmd.op = OP_ADVANCE;
      end else begin
         cmd.op     = OP_START;
         cmd.low_x  = req_ch.payload.low_x;
         cmd.low_y  = req_ch.payload.low_y;
         cmd.low_z  = req_ch.payload.low_z;
         cmd.high_x = req_ch.payload.high_x;
         cmd.high_y = req_ch.payload.high_y;
         cmd.high_z = req_ch.payload.high_z;
      end
   end

   assign req_ch.ready = !full;
   assign push         = req_ch.valid && !full;
   assign cmd_ch.valid = !empty;
   assign pop          = cmd_ch.valid && cmd_ch.ready;

   mbeig_queue #(.DEPTH(DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (cmd),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (cmd_ch.payload)
   );
endmodule

@@ rtl/core/mbeig_mod.sv @@
// Restoring remainder unit: one quotient bit per cycle
module mbeig_mod #(
   parameter int EXT_W = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mbeig_pkg::VAL_W-1:0] value,
   input  logic [EXT_W-1:0]           divisor,
   output logic                       busy,
   output logic [EXT_W-1:0]           rem
);
   import mbeig_pkg::*;

   localparam int CNT_W = $clog2(VAL_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VAL_W - 1);

   logic [VAL_W-1:0] dividend_ff, dividend_in;
   logic [EXT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [EXT_W:0]   rem_sh;
   logic [EXT_W:0]   rem_sub;

   assign busy = busy_ff;
   assign rem  = rem_ff;

   always_comb begin
      rem_sh      = {rem_ff, dividend_ff[VAL_W-1]};
      rem_sub     = rem_sh - {1'b0, divisor};
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      if (start) begin
         dividend_in = value;
         rem_in      = '0;
         cnt_in      = '0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[VAL_W-2:0], 1'b0};
         rem_in      = (rem_sh >= {1'b0, divisor}) ? rem_sub[EXT_W-1:0] : rem_sh[EXT_W-1:0];
         cnt_in      = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
   end
endmodule

@@ rtl/core/mbeig_back.sv @@
// Back part: walk state, coordinate wrap and element number pipeline
`include "mesh_box_element_index_generator_top_macros.svh"

module mbeig_back #(
   parameter int MAX_EXTENT = mbeig_pkg::DEF_MAX_EXTENT
) (
   input logic               clock,
   input logic               reset,
   input mbeig_pkg::cfg_type cfg,
   mbeig_chan_if.sink        cmd_ch,
   mbeig_chan_if.source      rsp_ch
);
   import mbeig_pkg::*;

   localparam int EXT_W  = $clog2(MAX_EXTENT + 1);
   localparam int ZY_W   = COORD_W + EXT_W;
   localparam int P1_W   = ZY_W + 1;
   localparam int XY_W   = P1_W + EXT_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WRAP  = 5'b00010,
      ST_ELEM1 = 5'b00100,
      ST_ELEM2 = 5'b01000,
      ST_ELEM3 = 5'b10000
   } state_type;

   function automatic logic [EXT_W-1:0] eff_extent(input coord_type e);
      if (e == '0 || 32'(e) > MAX_EXTENT) begin
         return EXT_W'(MAX_EXTENT);
      end
      return EXT_W'(e);
   endfunction

   state_type          state_ff, state_in;
   coord_type          cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, cur_z_ff, cur_z_in;
   coord_type          start_x_ff, start_x_in, start_y_ff, start_y_in;
   coord_type          end_x_ff, end_x_in, end_y_ff, end_y_in, end_z_ff, end_z_in;
   logic [SUB_W-1:0]   sub_ff, sub_in;
   logic               running_ff, running_in;
   logic               misuse_ff, misuse_in;
   logic [P1_W-1:0]    p1_ff, p1_in;
   logic [ELEM_W-1:0]  prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [DIMS_W-1:0]  dims;
   logic [SUB_W-1:0]   per;
   logic [EXT_W-1:0]   ext_x, ext_y, ext_z;
   cmd_type            cmd;
   logic               pop, start_pop, misuse_pop, roll_pop, rollover;
   logic [VAL_W-1:0]   nx, ny, nz;
   logic               run_next;
   logic [2:0]         mod_busy;
   logic [EXT_W-1:0]   rem_x, rem_y, rem_z;
   logic [ZY_W-1:0]    zy_prod;
   logic [P1_W-1:0]    mul_a;
   logic [XY_W-1:0]    xy_prod;
   logic [ELEM_W-1:0]  el;
   logic               rsp_load;

   assign dims  = (cfg.dims == '0) ? DIMS_1D : cfg.dims;
   assign ext_x = eff_extent(cfg.extent_x);
   assign ext_y = eff_extent(cfg.extent_y);
   assign ext_z = eff_extent(cfg.extent_z);

   always_comb begin
      case (dims)
         DIMS_1D: per = PER_1D;
         DIMS_2D: per = PER_2D;
         default: per = PER_3D;
      endcase
   end

   assign cmd          = cmd_ch.payload;
   assign cmd_ch.ready = (state_ff == ST_IDLE);
   assign pop          = cmd_ch.valid && (state_ff == ST_IDLE);
   assign start_pop    = pop && (cmd.op == OP_START);
   assign misuse_pop   = pop && (cmd.op == OP_ADVANCE) && !running_ff;
   assign rollover     = !(({1'b0, sub_ff} + 4'd1) < {1'b0, per});
   assign roll_pop     = pop && (cmd.op == OP_ADVANCE) && running_ff && rollover;

   // Next section position, nested loops with x fastest
   always_comb begin
      nx       = {1'b0, cur_x_ff} + 1'b1;
      ny       = {1'b0, cur_y_ff};
      nz       = {1'b0, cur_z_ff};
      run_next = running_ff;
      if (dims == DIMS_1D) begin
         if (nx == {1'b0, end_x_ff}) begin
            run_next = 1'b0;
         end
      end else if (nx == {1'b0, end_x_ff}) begin
         ny = {1'b0, cur_y_ff} + 1'b1;
         if (dims == DIMS_2D) begin
            if (ny == {1'b0, end_y_ff}) begin
               run_next = 1'b0;
            end
         end else if (ny == {1'b0, end_y_ff}) begin
            nz = {1'b0, cur_z_ff} + 1'b1;
            if (nz == {1'b0, end_z_ff}) begin
               run_next = 1'b0;
            end
            ny = {1'b0, start_y_ff};
         end
         nx = {1'b0, start_x_ff};
      end
   end

   mbeig_mod #(.EXT_W(EXT_W)) u_mod_x (
      .clock(clock), .reset(reset), .start(roll_pop), .value(nx),
      .divisor(ext_x), .busy(mod_busy[0]), .rem(rem_x)
   );
   mbeig_mod #(.EXT_W(EXT_W)) u_mod_y (
      .clock(clock), .reset(reset), .start(roll_pop), .value(ny),
      .divisor(ext_y), .busy(mod_busy[1]), .rem(rem_y)
   );
   mbeig_mod #(.EXT_W(EXT_W)) u_mod_z (
      .clock(clock), .reset(reset), .start(roll_pop), .value(nz),
      .divisor(ext_z), .busy(mod_busy[2]), .rem(rem_z)
   );

   // Element number: (y + z*ey), then times ex plus x, then scale by per and add sub; 2D uses y alone, 1D gives x
   assign zy_prod = cur_z_ff * ext_y;
   assign mul_a   = (dims == DIMS_2D) ? P1_W'(cur_y_ff) : p1_ff;
   assign xy_prod = mul_a * ext_x;

   always_comb begin
      case (dims)
         DIMS_1D: el = ELEM_W'(cur_x_ff);
         DIMS_2D: el = {prod_ff[ELEM_W-2:0], 1'b0} + ELEM_W'(sub_ff);
         default: el = {prod_ff[ELEM_W-3:0], 2'b00} + {prod_ff[ELEM_W-2:0], 1'b0}
                       + ELEM_W'(sub_ff);
      endcase
   end

   assign rsp_load = (state_ff == ST_ELEM3) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in   = state_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      cur_z_in   = cur_z_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      end_x_in   = end_x_ff;
      end_y_in   = end_y_ff;
      end_z_in   = end_z_ff;
      sub_in     = sub_ff;
      running_in = running_ff;
      misuse_in  = misuse_ff;
      p1_in      = p1_ff;
      prod_in    = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in  = ST_ELEM1;
               misuse_in = 1'b0;
               if (cmd.op == OP_START) begin
                  cur_x_in   = cmd.low_x;
                  cur_y_in   = cmd.low_y;
                  cur_z_in   = cmd.low_z;
                  start_x_in = cmd.low_x;
                  start_y_in = cmd.low_y;
                  end_x_in   = cmd.high_x;
                  end_y_in   = cmd.high_y;
                  end_z_in   = cmd.high_z;
                  sub_in     = '0;
                  running_in = (cmd.low_x != cmd.high_x)
                               && (dims == DIMS_1D || cmd.low_y != cmd.high_y)
                               && (dims != DIMS_3D || cmd.low_z != cmd.high_z);
               end else if (!running_ff) begin
                  misuse_in = 1'b1;
               end else if (!rollover) begin
                  sub_in = sub_ff + 1'b1;
               end else begin
                  sub_in     = '0;
                  running_in = run_next;
                  state_in   = ST_WRAP;
               end
            end
         end
         ST_WRAP: begin
            if (mod_busy == '0) begin
               cur_x_in = COORD_W'(rem_x);
               if (dims != DIMS_1D) begin
                  cur_y_in = COORD_W'(rem_y);
               end
               if (dims == DIMS_3D) begin
                  cur_z_in = COORD_W'(rem_z);
               end
               state_in = ST_ELEM1;
            end
         end
         ST_ELEM1: begin
            p1_in    = P1_W'(zy_prod) + P1_W'(cur_y_ff);
            state_in = ST_ELEM2;
         end
         ST_ELEM2: begin
            prod_in  = ELEM_W'(xy_prod) + ELEM_W'(cur_x_ff);
            state_in = ST_ELEM3;
         end
         ST_ELEM3: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result until the receiver takes it
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.sec_x          = cur_x_ff;
         rsp_in.sec_y          = cur_y_ff;
         rsp_in.sec_z          = cur_z_ff;
         rsp_in.sub_index      = sub_ff;
         rsp_in.element_number = el;
         rsp_in.finished       = !running_ff;
         rsp_in.misuse         = misuse_ff;
         rsp_valid_in          = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cur_z_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         end_z_ff     <= '0;
         sub_ff       <= '0;
         running_ff   <= 1'b0;
         misuse_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cur_z_ff     <= cur_z_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         end_z_ff     <= end_z_in;
         sub_ff       <= sub_in;
         running_ff   <= running_in;
         misuse_ff    <= misuse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   `MBEIG_ASSERT_NEXT(a_misuse_keeps_state, clock, reset, misuse_pop, $stable(cur_x_ff) && $stable(cur_y_ff) && $stable(cur_z_ff) && $stable(sub_ff) && !running_ff, "advance after finishing changed the walk state")
   `MBEIG_ASSERT(a_misuse_is_finished, clock, reset, rsp_load && misuse_ff |-> !running_ff, "misuse result without finished")
   `MBEIG_ASSERT_NEXT(a_start_clears_sub, clock, reset, start_pop, sub_ff == '0 && state_ff == ST_ELEM1, "start did not clear the sub-element counter")
   `MBEIG_ASSERT_NEXT(a_roll_runs_wrap, clock, reset, roll_pop, state_ff == ST_WRAP && mod_busy == 3'b111, "section step did not launch the remainder units")
endmodule

@@ rtl/core/mesh_box_element_index_generator_top.sv @@
// Top level of the box walk address generator over a periodic mesh
//
// Channels: req_ch takes start transactions (action 0, box corners) and
// advance transactions (action 1). rsp_ch returns one result per request:
// section coordinates, sub-element, linear element number and the
// finished and misuse flags. csr_ch writes the dimensions and extent
// registers; it is always ready. The user must see that it is written only
// while the block is idle; the block itself does not enforce this.
// Flow: a start, a misuse advance or an advance inside a section passes
// the ELEM1, ELEM2 and ELEM3 states into the result register; an advance
// that steps the section first waits in WRAP on the 12-step restoring
// remainder units. The back part takes one request at a time, none before
// the last is loaded; a two-entry command queue takes requests until full.
// Reset: walk state clears, no walk runs, dimensions reset to 3 and the
// extents to MAX_EXTENT. A stalled receiver holds the result register; the
// next request is still processed up to the final stage.
module mesh_box_element_index_generator_top #(
   parameter int MAX_EXTENT = mbeig_pkg::DEF_MAX_EXTENT,
   parameter int DEPTH      = mbeig_pkg::QUEUE_DEPTH
) (
   input logic          clock,
   input logic          reset,
   mbeig_chan_if.sink   req_ch,
   mbeig_chan_if.source rsp_ch,
   mbeig_chan_if.sink   csr_ch
);
   import mbeig_pkg::*;

   // An extent beyond the register width reads as zero, which selects MAX_EXTENT
   localparam coord_type EXT_RESET =
      COORD_W'((MAX_EXTENT >= (1 << COORD_W)) ? 0 : MAX_EXTENT);

   cfg_type cfg_ff, cfg_in;
   csr_type csr;

   mbeig_chan_if #(.payload_type(cmd_type)) cmd_ch ();

   assign csr          = csr_ch.payload;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (reg_index_type'(csr.reg_index))
            REG_DIMS:     cfg_in.dims     = csr.wdata[DIMS_W-1:0];
            REG_EXTENT_X: cfg_in.extent_x = csr.wdata;
            REG_EXTENT_Y: cfg_in.extent_y = csr.wdata;
            REG_EXTENT_Z: cfg_in.extent_z = csr.wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dims     <= DIMS_3D;
         cfg_ff.extent_x <= EXT_RESET;
         cfg_ff.extent_y <= EXT_RESET;
         cfg_ff.extent_z <= EXT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbeig_front #(.DEPTH(DEPTH)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cmd_ch (cmd_ch)
   );

   mbeig_back #(.MAX_EXTENT(MAX_EXTENT)) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd_ch (cmd_ch),
      .rsp_ch (rsp_ch)
   );
endmodule
